### hw/rtl/filename_crc32c_hash_defines.svh
// assertion macros used by the checker file
`ifndef FILENAME_CRC32C_HASH_DEFINES_SVH
`define FILENAME_CRC32C_HASH_DEFINES_SVH

// same-cycle implication, reset masks the check
`define FCH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masks the check
`define FCH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fch_pkg.sv
// package: constants and the crc32c word-update matrix for the name hash
package fch_pkg;

  localparam int unsigned HASH_BITS_DEF   = 22;
  localparam int unsigned HASH_FIELD_BITS = 22;
  localparam int unsigned CRC_W           = 32;
  localparam int unsigned CHAR_W          = 8;

  localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY  = 32'h82F6_3B78;
  localparam logic [CHAR_W-1:0] ASCII_MAX = 8'h7F;
  localparam logic [CHAR_W-1:0] UPPER_LO  = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_HI  = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_BIT  = 8'h20;

  typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

  // column j: effect of register bit j after 32 reflected shift steps
  function automatic crc_mat_t crc_cols();
    crc_mat_t m;
    logic [CRC_W-1:0] r;
    for (int j = 0; j < CRC_W; j++) begin
      r = CRC_W'(1) << j;
      for (int s = 0; s < CRC_W; s++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      m[j] = r;
    end
    return m;
  endfunction

  localparam crc_mat_t CRC_MAT = crc_cols();

endpackage

### hw/rtl/fch_if.sv
// handshake channels: name characters in, hash results out
interface fch_in_if;
  import fch_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface fch_out_if #(
  parameter int unsigned HASH_BITS = fch_pkg::HASH_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [HASH_BITS-1:0] name_hash;
  logic                 not_ascii;

  modport source (output valid, output name_hash, output not_ascii, input ready);
  modport sink   (input valid, input name_hash, input not_ascii, output ready);
endinterface

### hw/rtl/fch_crc_step.sv
// one character: case fold, then crc32c over its zero-extended 32-bit word
module fch_crc_step
  import fch_pkg::*;
(
  input  logic [CRC_W-1:0]  crc_in,
  input  logic [CHAR_W-1:0] char_code,
  output logic [CRC_W-1:0]  crc_out,
  output logic              high_char
);

  logic [CHAR_W-1:0] folded;
  logic [CRC_W-1:0]  mixed;

  // fold upper-case ascii to lower case
  always_comb begin
    folded = char_code;
    if (char_code >= UPPER_LO && char_code <= UPPER_HI) begin
      folded = char_code | CASE_BIT;
    end
  end

  assign high_char = (char_code > ASCII_MAX);
  assign mixed     = crc_in ^ {{(CRC_W-CHAR_W){1'b0}}, folded};

  // linear xor network: 32 shift steps folded into one matrix
  always_comb begin
    crc_out = '0;
    for (int j = 0; j < CRC_W; j++) begin
      if (mixed[j]) begin
        crc_out = crc_out ^ CRC_MAT[j];
      end
    end
  end

endmodule

### hw/rtl/filename_crc32c_hash.sv
// top level: streaming crc32c name hash with sticky non-ascii flag
//
//  channel   dir   payload                      transfer when
//  in_ch     in    char_code[7:0], last         valid && ready
//  out_ch    out   name_hash[HASH_BITS-1:0],    valid && ready
//                  not_ascii
//
// one character per cycle while the input is not stalled; the crc word update
// is a single xor layer between the crc state register and the result register.
// a result appears the cycle after its last character is taken.
// synchronous active-low reset: crc to all ones, sticky non-ascii state and out valid clear.
// input stalls only while an unread result sits in the output register.
module filename_crc32c_hash
  import fch_pkg::*;
#(
  parameter int unsigned HASH_BITS = HASH_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fch_in_if.sink    in_ch,
  fch_out_if.source out_ch
);

  logic [CRC_W-1:0]     crc_r, crc_nxt;
  logic                 bad_r, bad_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [HASH_BITS-1:0] hash_r, hash_nxt;
  logic                 flag_r, flag_nxt;

  logic [CRC_W-1:0]     crc_new;
  logic                 high_char;
  logic                 in_xfer;
  logic                 bad_new;

  fch_crc_step u_step (
    .crc_in    (crc_r),
    .char_code (in_ch.char_code),
    .crc_out   (crc_new),
    .high_char (high_char)
  );

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign bad_new     = bad_r || high_char;

  // state update and result capture
  always_comb begin
    crc_nxt       = crc_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    hash_nxt      = hash_r;
    flag_nxt      = flag_r;
    if (in_xfer) begin
      if (in_ch.last) begin
        crc_nxt       = CRC_INIT;
        bad_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
        flag_nxt      = bad_new;
        for (int i = 0; i < HASH_BITS; i++) begin
          hash_nxt[i] = (i < HASH_FIELD_BITS) ? crc_new[i] : 1'b0;
        end
      end else begin
        crc_nxt = crc_new;
        bad_nxt = bad_new;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= CRC_INIT;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
    flag_r <= flag_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.name_hash = hash_r;
  assign out_ch.not_ascii = flag_r;

endmodule

### hw/rtl/fch_checker.sv
// port-level checker for the name hash, bound to the top level
`include "filename_crc32c_hash_defines.svh"

module fch_checker #(
  parameter int unsigned HASH_BITS = fch_pkg::HASH_BITS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 in_last,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [HASH_BITS-1:0] out_hash,
  input logic                 out_flag
);

  logic in_xfer;
  logic out_held;

  assign in_xfer  = in_valid && in_ready;
  assign out_held = out_valid && !out_ready;

  // a stalled result keeps its payload
  `FCH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held,
    out_valid && $stable(out_hash) && $stable(out_flag), "result changed while stalled")

  // a last character always yields a result next cycle
  `FCH_ASSERT_NEXT(a_last_result, clk, rst_n, in_xfer && in_last, out_valid,
    "no result after last character")

  // no result appears without a last character
  `FCH_ASSERT_NEXT(a_no_spurious, clk, rst_n, !out_held && !(in_xfer && in_last),
    !out_valid, "result without last character")

  // input is blocked while a result waits
  `FCH_ASSERT_NOW(a_stall_in, clk, rst_n, out_held, !in_ready,
    "input taken while result pending")

endmodule

bind filename_crc32c_hash fch_checker #(.HASH_BITS(HASH_BITS)) u_fch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.name_hash),
  .out_flag  (out_ch.not_ascii)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// testbench: streams directory-entry names through the crc32c name hash and checks every result
module tb_top;
  import fch_pkg::*;

  localparam int unsigned HASH_W     = HASH_BITS_DEF;
  localparam int          NAME_CHARS = 1150;
  localparam int          TAIL_CHARS = 1000;

  typedef struct packed {
    logic [HASH_W-1:0] name_hash;
    logic              not_ascii;
  } hash_rec_t;

  // predicts the hash of each name and holds the hashes still owed by the block
  class name_hash_scoreboard;
    logic [CRC_W-1:0] crc_state;
    logic             non_ascii_seen;
    hash_rec_t        pending_hashes[$];
    int               mismatches;
    int               names_done;
    int               flagged_names;

    function new();
      mismatches    = 0;
      names_done    = 0;
      flagged_names = 0;
      rearm();
    endfunction

    function void rearm();
      crc_state      = CRC_INIT;
      non_ascii_seen = 1'b0;
    endfunction

    // fold case, absorb the zero-extended 32-bit word, close the name on last
    function void note_char(logic [CHAR_W-1:0] raw, logic is_last);
      logic [CHAR_W-1:0] folded;
      hash_rec_t         rec;
      folded = raw;
      if (raw > ASCII_MAX) non_ascii_seen = 1'b1;
      if (raw >= UPPER_LO && raw <= UPPER_HI) folded = raw | CASE_BIT;
      crc_state = crc_state ^ {{(CRC_W-CHAR_W){1'b0}}, folded};
      for (int s = 0; s < CRC_W; s++) begin
        crc_state = crc_state[0] ? ((crc_state >> 1) ^ CRC_POLY) : (crc_state >> 1);
      end
      if (is_last) begin
        rec.name_hash = crc_state[HASH_W-1:0];
        rec.not_ascii = non_ascii_seen;
        pending_hashes = {pending_hashes, rec};
        rearm();
      end
    endfunction

    // compare one result transfer with the oldest owed hash
    function void check_result(logic [HASH_W-1:0] hash, logic flag);
      hash_rec_t exp_rec;
      if (pending_hashes.size() == 0) begin
        $error("unexpected result: name_hash %h not_ascii %b", hash, flag);
        mismatches++;
        return;
      end
      exp_rec = pending_hashes.pop_front();
      if (hash !== exp_rec.name_hash) begin
        $error("name_hash mismatch: expected %h, actual %h", exp_rec.name_hash, hash);
        mismatches++;
      end
      if (flag !== exp_rec.not_ascii) begin
        $error("not_ascii mismatch: expected %b, actual %b", exp_rec.not_ascii, flag);
        mismatches++;
      end
      names_done++;
      if (exp_rec.not_ascii) flagged_names++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic quiet_tail;
  int   chars_sent;

  name_hash_scoreboard sb;

  fch_in_if                        in_ch ();
  fch_out_if #(.HASH_BITS(HASH_W)) out_ch ();

  filename_crc32c_hash #(
    .HASH_BITS(HASH_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character mix: printable, upper and lower case, digits, boundaries, any byte and high bytes
  function automatic logic [CHAR_W-1:0] rand_char();
    logic [CHAR_W-1:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = CHAR_W'($urandom_range(8'h20, 8'h7E));
      3, 4:    c = CHAR_W'($urandom_range(UPPER_LO, UPPER_HI));
      5:       c = CHAR_W'($urandom_range(8'h61, 8'h7A));
      6:       c = CHAR_W'($urandom_range(0, 255));
      7:       c = CHAR_W'($urandom_range(8'h80, 8'hFF));
      8: begin
        case ($urandom_range(0, 7))
          0:       c = 8'h00;
          1:       c = 8'h40;
          2:       c = UPPER_LO;
          3:       c = UPPER_HI;
          4:       c = 8'h5B;
          5:       c = ASCII_MAX;
          6:       c = 8'h80;
          default: c = 8'hFF;
        endcase
      end
      default: c = CHAR_W'($urandom_range(8'h2D, 8'h39));
    endcase
    return c;
  endfunction

  // one character transfer, with an optional idle burst ahead of it
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic is_last, input int gap_odds);
    int gap;
    @(negedge clk);
    if (!quiet_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
      gap = $urandom_range(1, 9);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.char_code = c;
    in_ch.last      = is_last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_char(c, is_last);
    chars_sent++;
  endtask

  task automatic send_name(input logic [CHAR_W-1:0] chars[$]);
    int gap_odds;
    case ($urandom_range(0, 2))
      0:       gap_odds = 0;
      1:       gap_odds = 2;
      default: gap_odds = 6;
    endcase
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1, gap_odds);
    end
  endtask

  // result side back-pressure, in phases of heavy, light or no stalling
  initial begin
    int stall_odds;
    int phase_left;
    out_ch.ready = 1'b0;
    stall_odds   = 0;
    phase_left   = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        stall_odds = $urandom_range(0, 2) * 4;
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      if (!quiet_tail && stall_odds != 0 && $urandom_range(0, stall_odds) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.name_hash, out_ch.not_ascii);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[filename_crc32c_hash] ERROR");
    $finish;
  end

  // reset, directed names, random names, drain
  initial begin
    logic [CHAR_W-1:0] name_buf[$];
    int                len;
    sb              = new();
    quiet_tail      = 1'b0;
    chars_sent      = 0;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.char_code = '0;
    in_ch.last      = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // case-fold edges, zero and high bytes
    name_buf = '{8'h41};            send_name(name_buf);
    name_buf = '{8'h5A};            send_name(name_buf);
    name_buf = '{8'h40};            send_name(name_buf);
    name_buf = '{8'h5B};            send_name(name_buf);
    name_buf = '{8'h61, 8'h7A};     send_name(name_buf);
    name_buf = '{8'h00};            send_name(name_buf);
    name_buf = '{8'hFF};            send_name(name_buf);
    name_buf = '{8'h7F};            send_name(name_buf);
    // high byte early: flag must stick to the end of the name
    name_buf = '{8'h80, 8'h61};     send_name(name_buf);
    // high byte on the last character
    name_buf = '{8'h4D, 8'h61, 8'h80}; send_name(name_buf);
    // mixed case name
    name_buf = '{8'h52, 8'h65, 8'h41, 8'h44, 8'h2E, 8'h54, 8'h78, 8'h74};
    send_name(name_buf);
    // clean name after the mixed-case one: state must have re-armed
    name_buf = '{8'h61};            send_name(name_buf);

    // random names, mostly short, a few long
    while (chars_sent < NAME_CHARS) begin
      if (chars_sent >= TAIL_CHARS) quiet_tail = 1'b1;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      name_buf.delete();
      for (int i = 0; i < len; i++) name_buf = {name_buf, rand_char()};
      send_name(name_buf);
    end
    quiet_tail = 1'b1;
    @(negedge clk);
    in_ch.valid = 1'b0;
    in_ch.last  = 1'b0;

    // drain owed hashes, then wait briefly for anything stray
    while (sb.pending_hashes.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("hashed %0d names from %0d characters, %0d of them carrying high bytes",
             sb.names_done, chars_sent, sb.flagged_names);
    $display("random stalls on both channels, case-fold edges and sticky flag covered");
    if (sb.mismatches == 0 && sb.pending_hashes.size() == 0) begin
      $display("[filename_crc32c_hash] OK");
    end else begin
      $display("[filename_crc32c_hash] ERROR");
    end
    $finish;
  end

endmodule
